// File: rtl/core/lsh_pkg.sv
// Shared types, constants and arithmetic for the 3x3 Laplacian sharpening filter.
`default_nettype none

package lsh_pkg;

  // Largest frame width the line store is sized for.
  localparam int unsigned MAX_WIDTH = 2048;

  // Geometry register reset values.
  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

  // Smallest legal frame dimension.
  localparam logic [11:0] MIN_DIM = 12'd3;

  // Register indexes, selected by address bit 2.
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] pix_ch0;
    logic [7:0] pix_ch1;
    logic [7:0] pix_ch2;
  } pix_t;

  localparam int unsigned PIX_W = $bits(pix_t);

  typedef struct packed {
    logic [7:0]  sharp_ch0;
    logic [7:0]  sharp_ch1;
    logic [7:0]  sharp_ch2;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic        frame_done;
  } sharp_t;

  // Position data that travels alongside a pixel through the pipeline.
  typedef struct packed {
    logic        emit;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic        frame_done;
  } meta_t;

  // 5*center minus the four direct neighbors, clamped to a byte.
  function automatic logic [7:0] sharpen_px(input logic [7:0] ctr, input logic [7:0] lft,
                                            input logic [7:0] rgt, input logic [7:0] abv,
                                            input logic [7:0] blw);
    logic signed [11:0] acc;
    acc = 12'sd5 * $signed({4'b0000, ctr})
        - $signed({4'b0000, lft}) - $signed({4'b0000, rgt})
        - $signed({4'b0000, abv}) - $signed({4'b0000, blw});
    if (acc < 12'sd0) begin
      return 8'd0;
    end else if (acc > 12'sd255) begin
      return 8'd255;
    end else begin
      return acc[7:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lsh_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module lsh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/lsh_regs.sv
// APB geometry registers and the effective last column and last row derived from them.
`default_nettype none

module lsh_regs #(
  parameter int unsigned MaxWidth = lsh_pkg::MAX_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:2]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic                        restart_o,
  output logic [$clog2(MaxWidth)-1:0] col_last_o,
  output logic [11:0]                 row_last_o
);

  localparam int unsigned ColW = $clog2(MaxWidth);

  logic [11:0] width_q, width_d;
  logic [11:0] height_q, height_d;
  logic        wr_en;
  logic [ColW:0] eff_width;
  logic [11:0]   eff_height;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (paddr[2])
        lsh_pkg::REG_IDX_WIDTH:  width_d  = pwdata[11:0];
        lsh_pkg::REG_IDX_HEIGHT: height_d = pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lsh_pkg::FRAME_WIDTH_RST;
      height_q <= lsh_pkg::FRAME_HEIGHT_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      lsh_pkg::REG_IDX_WIDTH:  prdata = {20'd0, width_q};
      lsh_pkg::REG_IDX_HEIGHT: prdata = {20'd0, height_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // Any geometry write restarts the frame at row 0, column 0.
  assign restart_o = wr_en;

  // Clamp the width to 3..MaxWidth and the height to at least 3.
  always_comb begin
    if (width_q < lsh_pkg::MIN_DIM) begin
      eff_width = (ColW + 1)'(3);
    end else if (32'(width_q) > 32'(MaxWidth)) begin
      eff_width = (ColW + 1)'(MaxWidth);
    end else begin
      eff_width = (ColW + 1)'(width_q);
    end
    eff_height = (height_q < lsh_pkg::MIN_DIM) ? lsh_pkg::MIN_DIM : height_q;
  end

  assign col_last_o = ColW'(eff_width - (ColW + 1)'(1));
  assign row_last_o = eff_height - 12'd1;

endmodule

`default_nettype wire

// File: rtl/core/lsh_kernel.sv
// Sharpening window: the five taps of the 3x3 neighborhood and the per-channel kernel.
`default_nettype none

module lsh_kernel (
  input  logic          clk_i,
  input  logic          shift_i,
  input  lsh_pkg::pix_t abv_i,
  input  lsh_pkg::pix_t mid_i,
  input  lsh_pkg::pix_t blw_i,
  output lsh_pkg::pix_t sharp_o
);

  // Only the taps that the kernel reads, and the stages that feed them, are kept: top row
  // columns 1..2, middle row columns 0..2, bottom row columns 1..2.
  lsh_pkg::pix_t top_q [2];
  lsh_pkg::pix_t mid_q [3];
  lsh_pkg::pix_t bot_q [2];

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      top_q[0] <= top_q[1];
      top_q[1] <= abv_i;
      mid_q[0] <= mid_q[1];
      mid_q[1] <= mid_q[2];
      mid_q[2] <= mid_i;
      bot_q[0] <= bot_q[1];
      bot_q[1] <= blw_i;
    end
  end

  assign sharp_o.pix_ch0 = lsh_pkg::sharpen_px(mid_q[1].pix_ch0, mid_q[0].pix_ch0,
                                               mid_q[2].pix_ch0, top_q[0].pix_ch0,
                                               bot_q[0].pix_ch0);
  assign sharp_o.pix_ch1 = lsh_pkg::sharpen_px(mid_q[1].pix_ch1, mid_q[0].pix_ch1,
                                               mid_q[2].pix_ch1, top_q[0].pix_ch1,
                                               bot_q[0].pix_ch1);
  assign sharp_o.pix_ch2 = lsh_pkg::sharpen_px(mid_q[1].pix_ch2, mid_q[0].pix_ch2,
                                               mid_q[2].pix_ch2, top_q[0].pix_ch2,
                                               bot_q[0].pix_ch2);

endmodule

`default_nettype wire

// File: rtl/core/laplacian_sharpen_3x3_rgb.sv
// A result reaches the output register after its taken pixel passes stage 1 and stage 2.
// Throughput: one pixel per cycle while the output is not stalled; the line RAM takes one read and one write a cycle.
// Emitted results lag the input by one row plus one pixel; border positions emit nothing.
// Reset clears counters, pipeline valids and geometry (640 x 480); the line RAM and the
// window taps keep whatever they hold, and no clearing pass runs after reset.
`default_nettype none

module laplacian_sharpen_3x3_rgb #(
  parameter int unsigned MaxWidth = lsh_pkg::MAX_WIDTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Pixel input channel
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lsh_pkg::pix_t   in_data_i,
  // Result output channel
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lsh_pkg::sharp_t out_data_o,
  // Geometry register port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:2]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned LineW = 2 * lsh_pkg::PIX_W;

  // ---------------------------------------------------------------------------
  // Geometry registers
  // ---------------------------------------------------------------------------
  logic            restart;
  logic [ColW-1:0] col_last;
  logic [11:0]     row_last;

  lsh_regs #(
    .MaxWidth(MaxWidth)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .restart_o (restart),
    .col_last_o(col_last),
    .row_last_o(row_last)
  );

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  //   stage 1: line RAM read in flight, pixel and position held
  //   stage 2: window holds the neighborhood, kernel evaluates
  //   output : registered result
  // Each stage takes a new transaction when it is empty or its occupant moves
  // on, so a stalled result only blocks input once every stage is full.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_load, s2_ready, s1_ready, s1_go, in_fire;

  lsh_pkg::meta_t s1_meta_q, s2_meta_q, s0_meta;
  lsh_pkg::pix_t  s1_px_q;
  logic [ColW-1:0] s1_col_q;

  assign out_load = !out_valid_q || out_ready_i;
  // A pixel that emits nothing leaves stage 2 without touching the output.
  assign s2_ready = !s2_valid_q || !s2_meta_q.emit || out_load;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s1_go    = s1_valid_q && s2_ready;

  assign in_ready_o = s1_ready;
  assign in_fire    = in_valid_i && s1_ready;

  always_comb begin
    s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
    s2_valid_d  = s2_ready ? s1_valid_q : s2_valid_q;
    out_valid_d = out_load ? (s2_valid_q && s2_meta_q.emit) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position of the next pixel
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] col_q, col_d;
  logic [11:0]     row_q, row_d;
  logic            at_col_end, at_row_end;
  logic [ColW:0]   col_less1;

  assign at_col_end = (col_q == col_last);
  assign at_row_end = (row_q == row_last);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (at_col_end) begin
        col_d = '0;
        row_d = at_row_end ? 12'd0 : row_q + 12'd1;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Decide at intake whether this pixel completes an interior neighborhood;
  // the emitted position is one row up and one column left.
  assign col_less1 = {1'b0, col_q} - (ColW + 1)'(1);

  always_comb begin
    s0_meta.emit       = (row_q >= 12'd2) && (col_q >= ColW'(2));
    s0_meta.out_row    = row_q - 12'd1;
    s0_meta.out_col    = 11'(col_less1);
    s0_meta.frame_done = at_row_end && at_col_end;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_px_q   <= in_data_i;
      s1_col_q  <= col_q;
      s1_meta_q <= s0_meta;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_meta_q <= s1_meta_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Line RAM: each word holds {two rows up, one row up} for a column.
  // Read at intake, write back {one row up, new pixel} as the pixel leaves
  // stage 1. The same column recurs no sooner than three pixels later, by
  // which time its write has retired, so no forwarding is needed. The read
  // port only fires on intake, so the read data holds while stage 1 stalls.
  // ---------------------------------------------------------------------------
  logic [LineW-1:0] line_rdata;
  lsh_pkg::pix_t    line_abv, line_mid;

  assign line_abv = lsh_pkg::pix_t'(line_rdata[LineW-1:lsh_pkg::PIX_W]);
  assign line_mid = lsh_pkg::pix_t'(line_rdata[lsh_pkg::PIX_W-1:0]);

  lsh_ram #(
    .Width(LineW),
    .Depth(MaxWidth)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_go),
    .waddr_i(s1_col_q),
    .wdata_i({line_mid, s1_px_q}),
    .re_i   (in_fire),
    .raddr_i(col_q),
    .rdata_o(line_rdata)
  );

  // ---------------------------------------------------------------------------
  // Window and kernel; the window advances as a pixel enters stage 2
  // ---------------------------------------------------------------------------
  lsh_pkg::pix_t sharp;

  lsh_kernel u_kernel (
    .clk_i  (clk_i),
    .shift_i(s1_go),
    .abv_i  (line_abv),
    .mid_i  (line_mid),
    .blw_i  (s1_px_q),
    .sharp_o(sharp)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  lsh_pkg::sharp_t out_q;

  always_ff @(posedge clk_i) begin
    if (out_load && s2_valid_q && s2_meta_q.emit) begin
      out_q.sharp_ch0  <= sharp.pix_ch0;
      out_q.sharp_ch1  <= sharp.pix_ch1;
      out_q.sharp_ch2  <= sharp.pix_ch2;
      out_q.out_row    <= s2_meta_q.out_row;
      out_q.out_col    <= s2_meta_q.out_col;
      out_q.frame_done <= s2_meta_q.frame_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/core/lsh_checker.sv
// Port-level checks for the sharpening filter, bound to the top level.
`default_nettype none

module lsh_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input lsh_pkg::pix_t   in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input lsh_pkg::sharp_t out_data_o,
  input logic            psel,
  input logic            penable,
  input logic            pwrite,
  input logic [2:2]      paddr,
  input logic [31:0]     pwdata,
  input logic [31:0]     prdata,
  input logic            pready
);

  // A waiting pixel holds its valid and payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("pixel changed while waiting");

  // A stalled result holds its valid and payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // With the output free to drain, the pipeline never blocks input.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input blocked while output can drain");

  // A register reads back the 12 bits just written, upper bits zero.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready |=>
      (paddr != $past(paddr)) ||
      (prdata == {20'd0, $past(pwdata[11:0])}))
    else $error("register readback mismatch");

endmodule

bind laplacian_sharpen_3x3_rgb lsh_checker u_lsh_checker (.*);

`default_nettype wire
